// File: hw/rtl/bdq_pkg.sv
// bdq_pkg: shared constants, codes and types of the bounded deque core
// no dependencies; imported by bounded_deque_with_delete_core and its testbench
`default_nettype none

package bdq_pkg;

   // fixed field widths of the request and response ports
   localparam int FUNC_W   = 3;
   localparam int VALUE_W  = 32;
   localparam int INDEX_W  = 6;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   // default sizing
   localparam int DEPTH_DEF      = 64;
   localparam int DATA_WIDTH_DEF = 32;

   // request function codes; 6 and 7 carry no meaning
   typedef enum logic [FUNC_W-1:0] {
      FN_PUSH_TAIL = 3'd0,
      FN_PUSH_HEAD = 3'd1,
      FN_POP_HEAD  = 3'd2,
      FN_POP_TAIL  = 3'd3,
      FN_DELETE    = 3'd4,
      FN_READ      = 3'd5
   } func_type;

   // response status codes
   typedef enum logic [STATUS_W-1:0] {
      STS_OK    = 2'd0,
      STS_EMPTY = 2'd1,
      STS_FULL  = 2'd2,
      STS_RANGE = 2'd3
   } status_type;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_READ,
      ST_DEL
   } state_type;

endpackage : bdq_pkg

`default_nettype wire

// File: hw/rtl/bdq_ram.sv
// bdq_ram: entry store, one write port and one read port, registered read data
// no dependencies; instantiated by bounded_deque_with_delete_core
`default_nettype none

module bdq_ram #(
   parameter int DEPTH      = 64,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [DATA_WIDTH-1:0]    wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [DATA_WIDTH-1:0]    rd_data
);

   logic [DATA_WIDTH-1:0] entries_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         entries_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= entries_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule : bdq_ram

`default_nettype wire

// File: hw/rtl/bounded_deque_with_delete_core.sv
// bounded_deque_with_delete_core: ring-buffered deque with delete-by-value
// depends on bdq_pkg and bdq_ram
//
//  channel    | ports                                          | direction
//  -----------+------------------------------------------------+----------
//  request    | start, busy, req_func, req_value, req_index    | in (busy out)
//  response   | rsp_valid, rsp_read_data, rsp_status,          | out
//             | rsp_entry_count, rsp_removed_count             |
//
// a request transfers on a clock edge with start high and busy low
// push, pop and unused codes: answered from the execute state with a registered strobe, busy low again with it
// read: an extra state for the registered read of the entry store
// delete: the compaction walk reads one entry of the ring per cycle
// reset is synchronous; the entry store is not cleared, only head, count and the other control registers
// the receiver cannot stall: rsp_valid is a one-cycle strobe
`default_nettype none

module bounded_deque_with_delete_core #(
   parameter int DEPTH      = bdq_pkg::DEPTH_DEF,
   parameter int DATA_WIDTH = bdq_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  wire logic [bdq_pkg::FUNC_W-1:0]    req_func,
   input  wire logic [bdq_pkg::VALUE_W-1:0]   req_value,
   input  wire logic [bdq_pkg::INDEX_W-1:0]   req_index,
   output logic                               rsp_valid,
   output logic      [bdq_pkg::VALUE_W-1:0]   rsp_read_data,
   output logic      [bdq_pkg::STATUS_W-1:0]  rsp_status,
   output logic      [bdq_pkg::COUNT_W-1:0]   rsp_entry_count,
   output logic      [bdq_pkg::COUNT_W-1:0]   rsp_removed_count
);

   import bdq_pkg::*;

   // slot address width and count width (count reaches DEPTH)
   localparam int AW   = $clog2(DEPTH);
   localparam int CW   = $clog2(DEPTH + 1);
   // width to compare a request index against the count
   localparam int CMPW = (CW > INDEX_W) ? CW : INDEX_W;

   // ring slot of the entry at position pos from the head
   function automatic logic [AW-1:0] slot_of(input logic [AW-1:0] hd,
                                             input logic [CW-1:0] pos);
      logic [AW:0] sum;
      sum = (AW+1)'(hd) + (AW+1)'(pos);
      if (sum >= (AW+1)'(DEPTH)) begin
         sum = sum - (AW+1)'(DEPTH);
      end
      return sum[AW-1:0];
   endfunction

   // control state
   state_type             state_ff,      state_in;
   logic [AW-1:0]         head_ff,       head_in;
   logic [CW-1:0]         count_ff,      count_in;
   logic [CW-1:0]         removed_ff,    removed_in;
   // delete walk: read position, write position, read data pending
   logic [CW-1:0]         rd_ff,         rd_in;
   logic [CW-1:0]         wr_ff,         wr_in;
   logic                  pend_ff,       pend_in;
   logic                  rsp_valid_ff,  rsp_valid_in;

   // captured request and response payload
   func_type              func_ff,       func_in;
   logic [DATA_WIDTH-1:0] value_ff,      value_in;
   logic [INDEX_W-1:0]    index_ff,      index_in;
   status_type            rsp_status_ff, rsp_status_in;
   logic [VALUE_W-1:0]    rsp_rdata_ff,  rsp_rdata_in;

   // entry store port
   logic                  mem_we;
   logic [AW-1:0]         mem_waddr;
   logic [DATA_WIDTH-1:0] mem_wdata;
   logic                  mem_re;
   logic [AW-1:0]         mem_raddr;
   logic [DATA_WIDTH-1:0] mem_rdata;

   // helpers
   logic                  full;
   logic                  empty;
   logic                  keep;
   logic                  drop;
   logic [CW-1:0]         wr_nx;
   logic [AW-1:0]         head_dec;

   bdq_ram #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign head_dec = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - AW'(1);

   // compaction: an entry read last cycle is either kept (moved down) or dropped
   assign keep  = pend_ff && (mem_rdata != value_ff);
   assign drop  = pend_ff && (mem_rdata == value_ff);
   assign wr_nx = keep ? wr_ff + CW'(1) : wr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         count_ff     <= '0;
         removed_ff   <= '0;
         rd_ff        <= '0;
         wr_ff        <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         count_ff     <= count_in;
         removed_ff   <= removed_in;
         rd_ff        <= rd_in;
         wr_ff        <= wr_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff       <= func_in;
      value_ff      <= value_in;
      index_ff      <= index_in;
      rsp_status_ff <= rsp_status_in;
      rsp_rdata_ff  <= rsp_rdata_in;
   end

   always_comb begin
      state_in      = state_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      removed_in    = removed_ff;
      rd_in         = rd_ff;
      wr_in         = wr_ff;
      pend_in       = 1'b0;
      rsp_valid_in  = 1'b0;
      func_in       = func_ff;
      value_in      = value_ff;
      index_in      = index_ff;
      rsp_status_in = rsp_status_ff;
      rsp_rdata_in  = rsp_rdata_ff;
      mem_we        = 1'b0;
      mem_waddr     = '0;
      mem_wdata     = value_ff;
      mem_re        = 1'b0;
      mem_raddr     = '0;

      unique case (state_ff)
         ST_IDLE: begin
            // request transfer: capture it, clear the removed tally
            if (start) begin
               func_in    = func_type'(req_func);
               value_in   = DATA_WIDTH'(req_value);
               index_in   = req_index;
               removed_in = '0;
               state_in   = ST_EXEC;
            end
         end

         ST_EXEC: begin
            // default: finish with ok status and no read data
            rsp_status_in = STS_OK;
            rsp_rdata_in  = '0;
            rsp_valid_in  = 1'b1;
            state_in      = ST_IDLE;
            case (func_ff)
               FN_PUSH_TAIL: begin
                  if (full) begin
                     rsp_status_in = STS_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = slot_of(head_ff, count_ff);
                     count_in  = count_ff + CW'(1);
                  end
               end
               FN_PUSH_HEAD: begin
                  if (full) begin
                     rsp_status_in = STS_FULL;
                  end else begin
                     mem_we    = 1'b1;
                     mem_waddr = head_dec;
                     head_in   = head_dec;
                     count_in  = count_ff + CW'(1);
                  end
               end
               FN_POP_HEAD: begin
                  if (empty) begin
                     rsp_status_in = STS_EMPTY;
                  end else begin
                     head_in  = slot_of(head_ff, CW'(1));
                     count_in = count_ff - CW'(1);
                  end
               end
               FN_POP_TAIL: begin
                  if (empty) begin
                     rsp_status_in = STS_EMPTY;
                  end else begin
                     count_in = count_ff - CW'(1);
                  end
               end
               FN_DELETE: begin
                  // start the compaction walk from the head
                  rsp_valid_in = 1'b0;
                  rd_in        = '0;
                  wr_in        = '0;
                  state_in     = ST_DEL;
               end
               FN_READ: begin
                  if (CMPW'(index_ff) >= CMPW'(count_ff)) begin
                     rsp_status_in = STS_RANGE;
                  end else begin
                     // index below count, so it fits the count width
                     rsp_valid_in = 1'b0;
                     mem_re       = 1'b1;
                     mem_raddr    = slot_of(head_ff, CW'(index_ff));
                     state_in     = ST_READ;
                  end
               end
               default: begin
                  // unused function codes leave the state alone
               end
            endcase
         end

         ST_READ: begin
            rsp_status_in = STS_OK;
            rsp_rdata_in  = VALUE_W'(mem_rdata);
            rsp_valid_in  = 1'b1;
            state_in      = ST_IDLE;
         end

         ST_DEL: begin
            // write position never passes the read position, so the write
            // and the next read always hit different slots
            if (keep) begin
               mem_we    = 1'b1;
               mem_waddr = slot_of(head_ff, wr_ff);
               mem_wdata = mem_rdata;
            end
            if (drop) begin
               removed_in = removed_ff + CW'(1);
            end
            wr_in = wr_nx;
            if (rd_ff != count_ff) begin
               mem_re    = 1'b1;
               mem_raddr = slot_of(head_ff, rd_ff);
               rd_in     = rd_ff + CW'(1);
               pend_in   = 1'b1;
            end else begin
               // last entry handled this cycle: survivors form the new count
               count_in      = wr_nx;
               rsp_status_in = STS_OK;
               rsp_rdata_in  = '0;
               rsp_valid_in  = 1'b1;
               state_in      = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_read_data     = rsp_rdata_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_entry_count   = COUNT_W'(count_ff);
   assign rsp_removed_count = COUNT_W'(removed_ff);

   // count never exceeds the ring size
   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("entry count above depth");

   // a transfer always moves the sequencer to the execute step
   a_accept_exec : assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_EXEC))
      else $error("accepted request not executed");

   // the strobe only appears once the sequencer is back at rest
   a_strobe_idle : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (state_ff == ST_IDLE))
      else $error("response strobe while busy");

   // compaction never writes ahead of what it has read
   a_walk_order : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DEL) |-> (wr_ff <= rd_ff))
      else $error("compaction write overtook read");

   // a dropped push leaves the store full
   a_full_drop : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && (rsp_status_ff == STS_FULL)) |-> full)
      else $error("full status with free space");

endmodule : bounded_deque_with_delete_core

`default_nettype wire

// File: dv/tb_bounded_deque_with_delete_core.sv
`timescale 1ns / 100ps
// tb_bounded_deque_with_delete_core: self-checking bench for the bounded deque core
// depends on bdq_pkg and bounded_deque_with_delete_core; directed table then random traffic

module tb_bounded_deque_with_delete_core;
   import bdq_pkg::*;

   localparam int DEPTH = 64;

   // codes with no defined function; the core must leave its state alone
   localparam logic [FUNC_W-1:0] FN_SPARE_6 = 3'd6;
   localparam logic [FUNC_W-1:0] FN_SPARE_7 = 3'd7;

   // one response as the core reports it
   typedef struct packed {
      logic [VALUE_W-1:0] read_data;
      status_type         status;
      logic [COUNT_W-1:0] entry_count;
      logic [COUNT_W-1:0] removed_count;
   } deque_result_t;

   // one row of the directed table; reps repeats the request with value += step
   typedef struct packed {
      logic [FUNC_W-1:0]  func;
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] index;
      logic [COUNT_W-1:0] reps;
      logic [VALUE_W-1:0] step;
      logic               typed;
      deque_result_t      result;
   } directed_row_t;

   localparam deque_result_t NO_RESULT = '{32'd0, STS_OK, 7'd0, 7'd0};

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [FUNC_W-1:0]   req_func;
   logic [VALUE_W-1:0]  req_value;
   logic [INDEX_W-1:0]  req_index;
   logic                rsp_valid;
   logic [VALUE_W-1:0]  rsp_read_data;
   logic [STATUS_W-1:0] rsp_status;
   logic [COUNT_W-1:0]  rsp_entry_count;
   logic [COUNT_W-1:0]  rsp_removed_count;

   bounded_deque_with_delete_core #(
      .DEPTH      (DEPTH),
      .DATA_WIDTH (32)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_func          (req_func),
      .req_value         (req_value),
      .req_index         (req_index),
      .rsp_valid         (rsp_valid),
      .rsp_read_data     (rsp_read_data),
      .rsp_status        (rsp_status),
      .rsp_entry_count   (rsp_entry_count),
      .rsp_removed_count (rsp_removed_count)
   );

   // shadow copy of the deque contents, head at index 0
   logic [VALUE_W-1:0] deque_shadow[$];
   // responses still owed by the core, oldest first
   deque_result_t      owed_results[$];

   // a directed row with a hand-written answer overrides the shadow's answer
   logic               row_typed;
   deque_result_t      row_result;

   int                 fail_count;
   int                 func_seen[8];
   int                 full_hits, empty_hits, range_hits, match_hits, peak_fill;

   // 4 ns clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // generous hard stop, far beyond the slowest legal run
   initial begin
      #4000000;
      $display("timeout at %0t with %0d responses outstanding", $time, owed_results.size());
      $display("RESULT: ERROR");
      $finish;
   end

   // apply one request to the shadow deque and return the response it must give
   function automatic deque_result_t apply_request(input logic [FUNC_W-1:0]  func,
                                                   input logic [VALUE_W-1:0] value,
                                                   input logic [INDEX_W-1:0] index);
      deque_result_t      res;
      logic [VALUE_W-1:0] kept[$];
      int                 removed;
      res = NO_RESULT;
      removed = 0;
      case (func)
         FN_PUSH_TAIL: begin
            if (deque_shadow.size() >= DEPTH) res.status = STS_FULL;
            else deque_shadow.push_back(value);
         end
         FN_PUSH_HEAD: begin
            if (deque_shadow.size() >= DEPTH) res.status = STS_FULL;
            else deque_shadow.push_front(value);
         end
         FN_POP_HEAD: begin
            if (deque_shadow.size() == 0) res.status = STS_EMPTY;
            else void'(deque_shadow.pop_front());
         end
         FN_POP_TAIL: begin
            if (deque_shadow.size() == 0) res.status = STS_EMPTY;
            else void'(deque_shadow.pop_back());
         end
         FN_DELETE: begin
            // survivors keep their order
            foreach (deque_shadow[i]) begin
               if (deque_shadow[i] == value) removed++;
               else kept.push_back(deque_shadow[i]);
            end
            deque_shadow = kept;
         end
         FN_READ: begin
            if (index >= deque_shadow.size()) res.status = STS_RANGE;
            else res.read_data = deque_shadow[index];
         end
         default: ;
      endcase
      res.entry_count   = COUNT_W'(deque_shadow.size());
      res.removed_count = COUNT_W'(removed);
      return res;
   endfunction

   task automatic compare_result(input deque_result_t want, input deque_result_t got);
      if (got.read_data !== want.read_data) begin
         $display("%0t read_data mismatch: expected %h actual %h",
                  $time, want.read_data, got.read_data);
         fail_count++;
      end
      if (got.status !== want.status) begin
         $display("%0t status mismatch: expected %0d actual %0d",
                  $time, want.status, got.status);
         fail_count++;
      end
      if (got.entry_count !== want.entry_count) begin
         $display("%0t entry_count mismatch: expected %0d actual %0d",
                  $time, want.entry_count, got.entry_count);
         fail_count++;
      end
      if (got.removed_count !== want.removed_count) begin
         $display("%0t removed_count mismatch: expected %0d actual %0d",
                  $time, want.removed_count, got.removed_count);
         fail_count++;
      end
   endtask

   // monitor: check the response strobe first, then log any request transfer
   always @(posedge clock) begin
      deque_result_t want;
      deque_result_t got;
      if (!reset && rsp_valid) begin
         got = '{rsp_read_data, status_type'(rsp_status), rsp_entry_count,
                 rsp_removed_count};
         if (owed_results.size() == 0) begin
            $display("%0t response with none outstanding: actual %h", $time, got);
            fail_count++;
         end else begin
            compare_result(owed_results.pop_front(), got);
         end
      end
      if (!reset && start && !busy) begin
         want = apply_request(req_func, req_value, req_index);
         // coverage tallies come from the shadow's own answer
         func_seen[req_func]++;
         if (want.status == STS_FULL)  full_hits++;
         if (want.status == STS_EMPTY) empty_hits++;
         if (want.status == STS_RANGE) range_hits++;
         if (want.removed_count != 0)  match_hits++;
         if (want.entry_count > peak_fill) peak_fill = want.entry_count;
         owed_results.push_back(row_typed ? row_result : want);
      end
   end

   // mostly back-to-back, some short pauses, the odd long one
   function automatic int pick_gap();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 65) return 0;
      if (roll < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // hold start low for the requested gap, then present the request until it transfers
   task automatic issue(input logic [FUNC_W-1:0]  func,
                        input logic [VALUE_W-1:0] value,
                        input logic [INDEX_W-1:0] index,
                        input logic               typed,
                        input deque_result_t      result,
                        input int                 gap);
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      row_typed  = typed;
      row_result = result;
      start     <= 1'b1;
      req_func  <= func;
      req_value <= value;
      req_index <= index;
      do @(posedge clock); while (busy);
   endtask

   // drop start, then wait until every response owed so far has been seen
   task automatic drain_results();
      @(negedge clock);
      start <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
   endtask

   directed_row_t directed_rows[27];

   initial begin
      logic [VALUE_W-1:0] value_pool[6];
      logic [FUNC_W-1:0]  func;
      logic [VALUE_W-1:0] value;
      logic [INDEX_W-1:0] index;
      int                 mode;
      int                 roll;
      int                 fill;
      int                 nogaps;

      reset      = 1'b1;
      start      = 1'b0;
      req_func   = FN_PUSH_TAIL;
      req_value  = '0;
      req_index  = '0;
      row_typed  = 1'b0;
      row_result = NO_RESULT;
      fail_count = 0;
      full_hits  = 0;
      empty_hits = 0;
      range_hits = 0;
      match_hits = 0;
      peak_fill  = 0;
      foreach (func_seen[i]) func_seen[i] = 0;

      // empty-store corners, both extremes of the word, wrap of the head,
      // a full store, delete of every entry
      directed_rows = '{
         '{FN_POP_HEAD,  32'h0,        6'd0,  7'd1,  32'd0, 1'b1, '{32'h0, STS_EMPTY, 7'd0, 7'd0}},
         '{FN_POP_TAIL,  32'h0,        6'd0,  7'd1,  32'd0, 1'b1, '{32'h0, STS_EMPTY, 7'd0, 7'd0}},
         '{FN_READ,      32'h0,        6'd0,  7'd1,  32'd0, 1'b1, '{32'h0, STS_RANGE, 7'd0, 7'd0}},
         '{FN_DELETE,    32'h0,        6'd0,  7'd1,  32'd0, 1'b1, '{32'h0, STS_OK,    7'd0, 7'd0}},
         '{FN_SPARE_6,   32'hFFFFFFFF, 6'd63, 7'd1,  32'd0, 1'b1, '{32'h0, STS_OK,    7'd0, 7'd0}},
         '{FN_SPARE_7,   32'h0,        6'd0,  7'd1,  32'd0, 1'b1, '{32'h0, STS_OK,    7'd0, 7'd0}},
         '{FN_PUSH_TAIL, 32'hFFFFFFFF, 6'd0,  7'd1,  32'd0, 1'b1, '{32'h0, STS_OK,    7'd1, 7'd0}},
         '{FN_PUSH_HEAD, 32'h0,        6'd0,  7'd1,  32'd0, 1'b1, '{32'h0, STS_OK,    7'd2, 7'd0}},
         '{FN_READ,      32'h0,        6'd0,  7'd1,  32'd0, 1'b1, '{32'h0, STS_OK,    7'd2, 7'd0}},
         '{FN_READ,      32'h0,        6'd1,  7'd1,  32'd0, 1'b1,
           '{32'hFFFFFFFF, STS_OK, 7'd2, 7'd0}},
         '{FN_READ,      32'h0,        6'd63, 7'd1,  32'd0, 1'b1, '{32'h0, STS_RANGE, 7'd2, 7'd0}},
         '{FN_PUSH_TAIL, 32'hFFFFFFFF, 6'd0,  7'd1,  32'd0, 1'b0, NO_RESULT},
         '{FN_PUSH_TAIL, 32'h12345678, 6'd0,  7'd1,  32'd0, 1'b0, NO_RESULT},
         '{FN_DELETE,    32'hFFFFFFFF, 6'd0,  7'd1,  32'd0, 1'b1, '{32'h0, STS_OK,    7'd2, 7'd2}},
         '{FN_READ,      32'h0,        6'd1,  7'd1,  32'd0, 1'b1,
           '{32'h12345678, STS_OK, 7'd2, 7'd0}},
         '{FN_DELETE,    32'h0000DEAD, 6'd0,  7'd1,  32'd0, 1'b1, '{32'h0, STS_OK,    7'd2, 7'd0}},
         '{FN_POP_TAIL,  32'h0,        6'd0,  7'd1,  32'd0, 1'b1, '{32'h0, STS_OK,    7'd1, 7'd0}},
         '{FN_POP_HEAD,  32'h0,        6'd0,  7'd1,  32'd0, 1'b1, '{32'h0, STS_OK,    7'd0, 7'd0}},
         '{FN_PUSH_TAIL, 32'h100,      6'd0,  7'd64, 32'd1, 1'b0, NO_RESULT},
         '{FN_PUSH_TAIL, 32'h0,        6'd0,  7'd1,  32'd0, 1'b1, '{32'h0, STS_FULL,  7'd64, 7'd0}},
         '{FN_PUSH_HEAD, 32'hFFFFFFFF, 6'd0,  7'd1,  32'd0, 1'b1, '{32'h0, STS_FULL,  7'd64, 7'd0}},
         '{FN_READ,      32'h0,        6'd63, 7'd1,  32'd0, 1'b1, '{32'h13F, STS_OK,  7'd64, 7'd0}},
         '{FN_READ,      32'h0,        6'd0,  7'd1,  32'd0, 1'b1, '{32'h100, STS_OK,  7'd64, 7'd0}},
         '{FN_DELETE,    32'h120,      6'd0,  7'd1,  32'd0, 1'b1, '{32'h0, STS_OK,    7'd63, 7'd1}},
         '{FN_POP_HEAD,  32'h0,        6'd0,  7'd63, 32'd0, 1'b0, NO_RESULT},
         '{FN_PUSH_HEAD, 32'h5A5A5A5A, 6'd0,  7'd64, 32'd0, 1'b0, NO_RESULT},
         '{FN_DELETE,    32'h5A5A5A5A, 6'd0,  7'd1,  32'd0, 1'b1, '{32'h0, STS_OK,    7'd0, 7'd64}}
      };

      // synchronous reset, released at a falling edge
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed table; repeated rows step the pushed word
      foreach (directed_rows[r]) begin
         for (int n = 0; n < directed_rows[r].reps; n++) begin
            issue(directed_rows[r].func, directed_rows[r].value + n * directed_rows[r].step,
                  directed_rows[r].index, directed_rows[r].typed, directed_rows[r].result,
                  pick_gap());
         end
      end
      // sender pauses until the core has answered everything
      drain_results();

      // random traffic in phases, each in a mode: 0 fills, 1 drains, 2 mixes
      for (int phase = 0; phase < 7; phase++) begin
         mode   = (phase == 0 || phase == 1 || phase == 4) ? 0 :
                  (phase == 3 || phase == 5) ? 1 : 2;
         nogaps = (phase % 3 == 1);
         // a handful of words per phase so that deletes find matches
         foreach (value_pool[i]) value_pool[i] = $urandom();
         value_pool[0] = (phase % 2) ? 32'hFFFFFFFF : 32'h0;
         for (int n = 0; n < 62; n++) begin
            roll  = $urandom_range(0, 99);
            fill  = deque_shadow.size();
            value = ($urandom_range(0, 3) == 0) ? $urandom()
                                                : value_pool[$urandom_range(0, 5)];
            index = INDEX_W'($urandom_range(0, 63));
            if (roll < 3) begin
               func = $urandom_range(0, 1) ? FN_SPARE_6 : FN_SPARE_7;
            end else if (roll < 8) begin
               func = FN_DELETE;
            end else if (roll < 24) begin
               func = FN_READ;
               // mostly valid positions, the rest anywhere in the index range
               if (fill > 0 && $urandom_range(0, 4) != 0)
                  index = INDEX_W'($urandom_range(0, fill - 1));
            end else if (roll < (mode == 0 ? 90 : mode == 1 ? 45 : 62)) begin
               func = $urandom_range(0, 1) ? FN_PUSH_TAIL : FN_PUSH_HEAD;
            end else begin
               func = $urandom_range(0, 1) ? FN_POP_HEAD : FN_POP_TAIL;
            end
            issue(func, value, index, 1'b0, NO_RESULT, nogaps ? 0 : pick_gap());
         end
         drain_results();
      end

      @(negedge clock);
      start <= 1'b0;
      drain_results();
      // a delete over a full store is the slowest request; let any stray strobe show
      repeat (80) @(posedge clock);

      $display("covered: %0d push tail, %0d push head, %0d pop head, %0d pop tail,",
               func_seen[FN_PUSH_TAIL], func_seen[FN_PUSH_HEAD],
               func_seen[FN_POP_HEAD], func_seen[FN_POP_TAIL]);
      $display("  %0d delete (%0d hit), %0d read, %0d spare; full %0d, empty %0d, range %0d, peak %0d",
               func_seen[FN_DELETE], match_hits, func_seen[FN_READ],
               func_seen[FN_SPARE_6] + func_seen[FN_SPARE_7],
               full_hits, empty_hits, range_hits, peak_fill);
      if (fail_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
